// File: hdl/mep_pkg.sv
// Shared types and constants of the Mandelbrot escape pixel unit.
// Holds the fixed-point format, register indexes, opcodes and saturation helper.
// No dependencies; the palette, top level and checker refer to it by scoped names.
package mep_pkg;

	localparam int FRACTION_BITS = 28;
	localparam int COLOUR_BITS = 24;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS = 32;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_X_ORIGIN = 3'd0,
		CFG_X_STEP = 3'd1,
		CFG_Y_ORIGIN = 3'd2,
		CFG_Y_STEP = 3'd3,
		CFG_MAX_ITERATIONS = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_PIXEL = 1'b1
	} op_t;

	localparam logic signed [31:0] X_ORIGIN_RESET = -32'sd671088640;
	localparam logic [30:0] X_STEP_RESET = 31'd1048576;
	localparam logic signed [31:0] Y_ORIGIN_RESET = 32'sd402653184;
	localparam logic [30:0] Y_STEP_RESET = 31'd786432;
	localparam logic [9:0] MAX_ITER_RESET = 10'd1023;

	localparam logic signed [32:0] QUARTER = 33'sd1 <<< (FRACTION_BITS - 2);
	localparam logic signed [32:0] ONE = 33'sd1 <<< FRACTION_BITS;
	localparam logic signed [32:0] TWO = 33'sd1 <<< (FRACTION_BITS + 1);
	localparam logic [31:0] SIXTEENTH = 32'd1 << (FRACTION_BITS - 4);
	localparam logic [36:0] FOUR = 37'd1 << (FRACTION_BITS + 2);

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'sd2147483647) begin
			sat32 = 32'sh7fffffff;
		end else if (v < -48'sd2147483648) begin
			sat32 = 32'sh80000000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

endpackage

// File: hdl/mep_if.sv
// Valid/ready channel interfaces for pixel requests and pixel results.
// Depends on nothing; the top level and the checker bind use them.
interface mep_in_if;
	logic valid;
	logic ready;
	logic opcode;
	logic [9:0] column;
	logic [9:0] row;
	logic [9:0] palette_index;
	logic [23:0] palette_colour;

	modport source(output valid, opcode, column, row, palette_index, palette_colour,
		input ready);
	modport sink(input valid, opcode, column, row, palette_index, palette_colour,
		output ready);
endinterface

interface mep_out_if;
	logic valid;
	logic ready;
	logic [21:0] byte_offset;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [9:0] escape_count;

	modport source(output valid, byte_offset, red, green, blue, escape_count, input ready);
	modport sink(input valid, byte_offset, red, green, blue, escape_count, output ready);
endinterface

// File: hdl/mep_palette.sv
// Palette memory: one write port, one registered read port.
// Depends on mep_pkg for the colour width.
module mep_palette #(
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [mep_pkg::COLOUR_BITS-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [mep_pkg::COLOUR_BITS-1:0] rdata
);

	logic [mep_pkg::COLOUR_BITS-1:0] mem [DEPTH];
	logic [mep_pkg::COLOUR_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/mandelbrot_escape_pixel_unit.sv
// Top level of the Mandelbrot escape pixel unit: sequencer, fixed-point datapath.
// Depends on mep_pkg, the channel interfaces in mep_if and the mep_palette memory.
//
// Usage: pixel_in carries one beat per item. A load beat (opcode 0) writes one
// palette colour in the cycle it is taken and produces no result. A pixel beat
// (opcode 1) forms c from the column, row and the origin/step registers, tests
// the main cardioid and the period-2 bulb, and otherwise iterates z = z*z + c.
// pixel_out carries one result beat per pixel: byte offset, palette colour and
// escape count. One item is worked on at a time; pixel_in.ready is high while
// the sequencer is idle.
// A pixel inside the cardioid or bulb passes through the coordinate, complex,
// square, sum, cardioid and decide states and then the palette read. Each
// iteration passes through the three multipliers and then the add/saturate
// step, until the pixel escapes or its count reaches the iteration limit.
// A finished result sits in the output register until pixel_out.ready; the
// next item is taken and computed meanwhile, and its result waits until the
// register is free. Reset empties the output, returns the sequencer to idle
// and loads the register defaults. The palette is not cleared. Configuration
// is written through cfg_we/cfg_index/cfg_data; the user must write it only
// while the unit is idle, since the block itself does not enforce this.
module mandelbrot_escape_pixel_unit #(
	parameter int IMAGE_WIDTH = 1024,
	parameter int IMAGE_HEIGHT = 1024,
	parameter int PALETTE_DEPTH = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [mep_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input logic [mep_pkg::CFG_DATA_BITS-1:0] cfg_data,
	mep_in_if.sink pixel_in,
	mep_out_if.source pixel_out
);

	localparam int PAL_AW = $clog2(PALETTE_DEPTH);
	localparam int F = mep_pkg::FRACTION_BITS;

	typedef enum logic [3:0] {
		ST_IDLE, ST_COORD, ST_CPLX, ST_SQR, ST_QSUM, ST_CARD, ST_DECIDE,
		ST_MUL, ST_ADD, ST_RD, ST_OUT
	} state_t;

	state_t state_q;

	logic signed [31:0] x_origin_q, y_origin_q;
	logic [30:0] x_step_q, y_step_q;
	logic [9:0] max_q;

	logic in_fire;
	logic [9:0] col_sat, row_sat;
	logic [9:0] col_q, row_q;
	logic [40:0] px_q, py_q;
	logic [23:0] lin_q;
	logic [21:0] off_q;
	logic signed [31:0] cx_q, cy_q;
	logic signed [32:0] a_w, b_w, cy_w;
	logic signed [32:0] a_q;
	logic [31:0] aa_q, y2c_q, bb_q;
	logic card_ok_q, bulb_ok_q, bulb_hit_q;
	logic [31:0] q_q;
	logic signed [33:0] qa_q;
	logic signed [66:0] cprod;
	logic signed [35:0] cp_q;
	logic signed [59:0] paa, pyy;
	logic signed [57:0] pbb;
	logic signed [31:0] x_q, y_q;
	logic signed [63:0] pxx, pyy2, pxy;
	logic signed [35:0] x2_q, y2_q, xy_q;
	logic [36:0] mag;
	logic escaped;
	logic [9:0] n_q;

	logic pal_we;
	logic [15:0] pidx_w, n_w;
	logic [PAL_AW-1:0] pal_waddr, pal_raddr;
	logic [mep_pkg::COLOUR_BITS-1:0] pal_rdata;

	logic out_load;
	logic out_valid_q;
	logic [21:0] out_off_q;
	logic [mep_pkg::COLOUR_BITS-1:0] out_colour_q;
	logic [9:0] out_count_q;

	assign in_fire = pixel_in.valid && pixel_in.ready;
	assign pixel_in.ready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || pixel_out.ready);

	always_comb begin
		col_sat = ({6'd0, pixel_in.column} > 16'(IMAGE_WIDTH - 1)) ?
			10'(IMAGE_WIDTH - 1) : pixel_in.column;
		row_sat = ({6'd0, pixel_in.row} > 16'(IMAGE_HEIGHT - 1)) ?
			10'(IMAGE_HEIGHT - 1) : pixel_in.row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q <= mep_pkg::X_ORIGIN_RESET;
			x_step_q <= mep_pkg::X_STEP_RESET;
			y_origin_q <= mep_pkg::Y_ORIGIN_RESET;
			y_step_q <= mep_pkg::Y_STEP_RESET;
			max_q <= mep_pkg::MAX_ITER_RESET;
		end else if (cfg_we) begin
			case (mep_pkg::cfg_reg_t'(cfg_index))
				mep_pkg::CFG_X_ORIGIN: x_origin_q <= cfg_data;
				mep_pkg::CFG_X_STEP: x_step_q <= cfg_data[30:0];
				mep_pkg::CFG_Y_ORIGIN: y_origin_q <= cfg_data;
				mep_pkg::CFG_Y_STEP: y_step_q <= cfg_data[30:0];
				mep_pkg::CFG_MAX_ITERATIONS: max_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		a_w = 33'(cx_q) - mep_pkg::QUARTER;
		b_w = 33'(cx_q) + mep_pkg::ONE;
		cy_w = 33'(cy_q);
		paa = 60'($signed(a_w[29:0])) * 60'($signed(a_w[29:0]));
		pyy = 60'($signed(cy_w[29:0])) * 60'($signed(cy_w[29:0]));
		pbb = 58'($signed(b_w[28:0])) * 58'($signed(b_w[28:0]));
		cprod = 67'($signed({1'b0, q_q})) * 67'(qa_q);
		pxx = 64'(x_q) * 64'(x_q);
		pyy2 = 64'(y_q) * 64'(y_q);
		pxy = 64'(x_q) * 64'(y_q);
		mag = 37'($unsigned(x2_q)) + 37'($unsigned(y2_q));
		escaped = (mag >= mep_pkg::FOUR);
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			col_q <= col_sat;
			row_q <= row_sat;
		end
		case (state_q)
			ST_COORD: begin
				px_q <= 41'(col_q) * 41'(x_step_q);
				py_q <= 41'(row_q) * 41'(y_step_q);
				lin_q <= 24'(row_q) * 24'(IMAGE_WIDTH) + 24'(col_q);
			end
			ST_CPLX: begin
				cx_q <= mep_pkg::sat32(48'(x_origin_q) + 48'($signed({1'b0, px_q})));
				cy_q <= mep_pkg::sat32(48'(y_origin_q) - 48'($signed({1'b0, py_q})));
				off_q <= lin_q[21:0] + {lin_q[20:0], 1'b0};
			end
			ST_SQR: begin
				a_q <= a_w;
				aa_q <= paa[59:F];
				y2c_q <= pyy[59:F];
				bb_q <= {2'b00, pbb[57:F]};
				card_ok_q <= (a_w > -mep_pkg::TWO) && (a_w < mep_pkg::TWO) &&
					(cy_w > -mep_pkg::TWO) && (cy_w < mep_pkg::TWO);
				bulb_ok_q <= (b_w > -mep_pkg::ONE) && (b_w < mep_pkg::ONE) &&
					(cy_w > -mep_pkg::ONE) && (cy_w < mep_pkg::ONE);
			end
			ST_QSUM: begin
				q_q <= aa_q + y2c_q;
				qa_q <= $signed({2'b00, aa_q + y2c_q}) + 34'(a_q);
				bulb_hit_q <= bulb_ok_q && ((bb_q + y2c_q) < mep_pkg::SIXTEENTH);
			end
			ST_CARD: begin
				cp_q <= cprod[63:F];
			end
			ST_DECIDE: begin
				x_q <= '0;
				y_q <= '0;
				if ((card_ok_q && (cp_q < $signed({6'd0, y2c_q[31:2]}))) || bulb_hit_q) begin
					n_q <= max_q;
				end else begin
					n_q <= '0;
				end
			end
			ST_MUL: begin
				x2_q <= pxx[63:F];
				y2_q <= pyy2[63:F];
				xy_q <= pxy[63:F];
			end
			ST_ADD: begin
				if (!escaped) begin
					x_q <= mep_pkg::sat32(48'(x2_q) - 48'(y2_q) + 48'(cx_q));
					y_q <= mep_pkg::sat32((48'(xy_q) <<< 1) + 48'(cy_q));
					n_q <= n_q + 10'd1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_off_q <= '0;
			out_colour_q <= '0;
			out_count_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_off_q <= off_q;
				out_colour_q <= pal_rdata;
				out_count_q <= n_q;
			end else if (pixel_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire && (mep_pkg::op_t'(pixel_in.opcode) == mep_pkg::OP_PIXEL)) begin
						state_q <= ST_COORD;
					end
				end
				ST_COORD: state_q <= ST_CPLX;
				ST_CPLX: state_q <= ST_SQR;
				ST_SQR: state_q <= ST_QSUM;
				ST_QSUM: state_q <= ST_CARD;
				ST_CARD: state_q <= ST_DECIDE;
				ST_DECIDE: begin
					if ((card_ok_q && (cp_q < $signed({6'd0, y2c_q[31:2]}))) || bulb_hit_q) begin
						state_q <= ST_RD;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (n_q >= max_q) begin
						state_q <= ST_RD;
					end else begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (escaped) begin
						state_q <= ST_RD;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_RD: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		pidx_w = {6'd0, pixel_in.palette_index};
		n_w = {6'd0, n_q};
		pal_waddr = pidx_w[PAL_AW-1:0];
		pal_we = in_fire && (mep_pkg::op_t'(pixel_in.opcode) == mep_pkg::OP_LOAD) &&
			(pidx_w < 16'(PALETTE_DEPTH));
		pal_raddr = (n_w > 16'(PALETTE_DEPTH - 1)) ? PAL_AW'(PALETTE_DEPTH - 1) :
			n_w[PAL_AW-1:0];
	end

	mep_palette #(
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk(clk),
		.we(pal_we),
		.waddr(pal_waddr),
		.wdata(pixel_in.palette_colour),
		.raddr(pal_raddr),
		.rdata(pal_rdata)
	);

	assign pixel_out.valid = out_valid_q;
	assign pixel_out.byte_offset = out_off_q;
	assign pixel_out.red = out_colour_q[23:16];
	assign pixel_out.green = out_colour_q[15:8];
	assign pixel_out.blue = out_colour_q[7:0];
	assign pixel_out.escape_count = out_count_q;

endmodule

// File: hdl/mep_checker.sv
// Port-level checks for the Mandelbrot escape pixel unit, bound to the top level.
// Depends on mep_pkg for register indexes and opcodes.
module mep_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [mep_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input logic [mep_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input logic in_valid,
	input logic in_ready,
	input logic in_opcode,
	input logic out_valid,
	input logic out_ready,
	input logic [9:0] out_escape_count
);

	logic [9:0] max_shadow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_shadow_q <= mep_pkg::MAX_ITER_RESET;
		end else if (cfg_we &&
			(mep_pkg::cfg_reg_t'(cfg_index) == mep_pkg::CFG_MAX_ITERATIONS)) begin
			max_shadow_q <= cfg_data[9:0];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_opcode == mep_pkg::OP_PIXEL) |=> !in_ready)
		else $error("input taken while a pixel is in progress");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_opcode == mep_pkg::OP_LOAD) && !out_valid |=> !out_valid)
		else $error("palette load produced a result beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_escape_count <= max_shadow_q)
		else $error("escape count above the iteration limit");

endmodule

bind mandelbrot_escape_pixel_unit mep_checker u_mep_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cfg_we(cfg_we),
	.cfg_index(cfg_index),
	.cfg_data(cfg_data),
	.in_valid(pixel_in.valid),
	.in_ready(pixel_in.ready),
	.in_opcode(pixel_in.opcode),
	.out_valid(pixel_out.valid),
	.out_ready(pixel_out.ready),
	.out_escape_count(pixel_out.escape_count)
);
